// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/ues_pkg.sv -----
// ---------------------------------------------------------------------------
// ues_pkg
// Types and constants of the ultrasonic echo scanner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ues_pkg;

  localparam int LINE_W   = 8;
  localparam int COUNT_W  = 16;
  localparam int TRIG_W   = 8;
  localparam int IDX_W    = 3;
  localparam int STEP_W   = 5;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] MAX_COUNT_RST      = 16'd33330;
  localparam logic [COUNT_W-1:0] DIVISOR_RST        = 16'd1075;
  localparam logic [TRIG_W-1:0]  TRIGGER_LENGTH_RST = 8'd10;
  localparam logic [STEP_W-1:0]  STEP_MAX           = 5'd31;
  localparam logic [COUNT_W-1:0] COUNT_MAX          = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_COUNT      = 2'd0,
    CFG_DIVISOR        = 2'd1,
    CFG_TRIGGER_LENGTH = 2'd2
  } cfg_reg_t;

endpackage

// ----- design/ultrasonic_echo_scanner_unit.sv -----
// ---------------------------------------------------------------------------
// ultrasonic_echo_scanner_unit
// Round-robin ultrasonic ranging: triggers one sensor at a time, times its
// echo and emits one status word per timer tick.
// ---------------------------------------------------------------------------
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+---------------------
//  input    | in_valid, in_ready, echo_lines            | one timer tick
//  output   | out_valid, out_ready, trigger_lines,      | one result per tick
//           | packet_valid, packet_byte, timed_out      |
//  config   | cfg_write, cfg_index, cfg_data            | register writes
//
// The scan state is updated at the accepting edge and the result lands in the
// output register in the same edge.
// One tick is accepted per cycle while the output register is empty or drained.
// A stalled output holds its result and blocks further ticks.
// Synchronous reset clears the scan state and loads the register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_echo_scanner_unit
  import ues_pkg::*;
#(
  parameter int NUM_SENSORS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LINE_W-1:0]     echo_lines,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LINE_W-1:0]     trigger_lines,
  output logic                  packet_valid,
  output logic [BYTE_W-1:0]     packet_byte,
  output logic                  timed_out
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SENSORS - 1);

  logic [COUNT_W-1:0] max_count;
  logic [COUNT_W-1:0] divisor;
  logic [TRIG_W-1:0]  trigger_length;

  logic [IDX_W-1:0]   sensor_index, sensor_index_next;
  logic [COUNT_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [COUNT_W-1:0] step_prescaler, step_prescaler_next;
  logic [STEP_W-1:0]  distance_steps, distance_steps_next;
  logic [LINE_W-1:0]  previous_echo;

  logic [LINE_W-1:0]  sel_bit;
  logic [LINE_W-1:0]  trig_next;
  logic               valid_next;
  logic               tmo_next;
  logic [BYTE_W-1:0]  byte_next;
  logic [COUNT_W-1:0] pre_inc;
  logic               take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count      <= MAX_COUNT_RST;
      divisor        <= DIVISOR_RST;
      trigger_length <= TRIGGER_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAX_COUNT:      max_count      <= cfg_data;
        CFG_DIVISOR:        divisor        <= cfg_data;
        CFG_TRIGGER_LENGTH: trigger_length <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_bit   = LINE_W'(1) << sensor_index;
    trig_next = ({8'd0, elapsed_ticks} < {16'd0, trigger_length} + 24'd0) ? sel_bit : '0;
    pre_inc   = step_prescaler + COUNT_W'(1);

    sensor_index_next   = sensor_index;
    elapsed_ticks_next  = elapsed_ticks;
    step_prescaler_next = step_prescaler;
    distance_steps_next = distance_steps;
    valid_next          = 1'b0;
    tmo_next            = 1'b0;
    byte_next           = '0;

    if ((echo_lines & sel_bit) != '0 && (previous_echo & sel_bit) == '0) begin
      // Echo edge wins over a timeout on the same tick.
      valid_next = 1'b1;
      byte_next  = {sensor_index, ~distance_steps};
    end else if (elapsed_ticks >= max_count) begin
      valid_next = 1'b1;
      tmo_next   = 1'b1;
      byte_next  = {sensor_index, {STEP_W{1'b0}}};
    end else begin
      if (elapsed_ticks != COUNT_MAX) begin
        elapsed_ticks_next = elapsed_ticks + COUNT_W'(1);
      end
      // A zero divisor counts a step on every tick, like a divisor of one.
      if (pre_inc >= divisor || pre_inc == '0) begin
        step_prescaler_next = '0;
        if (distance_steps != STEP_MAX) begin
          distance_steps_next = distance_steps + STEP_W'(1);
        end
      end else begin
        step_prescaler_next = pre_inc;
      end
    end

    if (valid_next) begin
      sensor_index_next   = (sensor_index >= IDX_LAST) ? '0 : sensor_index + IDX_W'(1);
      elapsed_ticks_next  = '0;
      step_prescaler_next = '0;
      distance_steps_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_index   <= '0;
      elapsed_ticks  <= '0;
      step_prescaler <= '0;
      distance_steps <= '0;
      previous_echo  <= '0;
    end else if (take) begin
      sensor_index   <= sensor_index_next;
      elapsed_ticks  <= elapsed_ticks_next;
      step_prescaler <= step_prescaler_next;
      distance_steps <= distance_steps_next;
      previous_echo  <= echo_lines;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      trigger_lines <= trig_next;
      packet_valid  <= valid_next;
      packet_byte   <= byte_next;
      timed_out     <= tmo_next;
    end
  end

endmodule

// ----- design/ues_checker.sv -----
// ---------------------------------------------------------------------------
// ues_checker
// Port-level checks on the result stream of the echo scanner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ues_checker
  import ues_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [LINE_W-1:0] trigger_lines,
  input logic              packet_valid,
  input logic [BYTE_W-1:0] packet_byte,
  input logic              timed_out
);

  // A result without a packet carries no byte and no timeout flag.
  `ASSERT_ALWAYS(a_no_packet_zero, clk, rst, !(out_valid && !packet_valid) || (packet_byte == '0 && !timed_out))

  // A timeout reports distance zero.
  `ASSERT_ALWAYS(a_timeout_dist, clk, rst, !(out_valid && timed_out) || packet_byte[STEP_W-1:0] == '0)

  // At most one trigger line is driven.
  `ASSERT_ALWAYS(a_trig_onehot, clk, rst, !out_valid || $onehot0(trigger_lines))

  // A stalled result transaction holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(packet_byte) && $stable(trigger_lines))

endmodule

bind ultrasonic_echo_scanner_unit ues_checker u_ues_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .trigger_lines (trigger_lines),
  .packet_valid  (packet_valid),
  .packet_byte   (packet_byte),
  .timed_out     (timed_out)
);
